FILE: rtl/prim_min_spanning_tree_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spanning tree unit
// Concurrent checks clocked on i_clk; compile with ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef PRIM_MIN_SPANNING_TREE_UNIT_DEFINES_SVH
`define PRIM_MIN_SPANNING_TREE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check while out of reset
`define PMST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pmst assertion failed");
// Check at every edge, reset included
`define PMST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("pmst assertion failed");
`else
`define PMST_ASSERT(lbl, prop)
`define PMST_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: rtl/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared sizes, codes and control types of the spanning tree unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmst_pkg;

    localparam int MAX_V      = 32;
    localparam int V_BITS     = $clog2(MAX_V);
    localparam int W_BITS     = 16;
    localparam int C_BITS     = W_BITS + 1;
    localparam int SUM_BITS   = 21;
    localparam int CNT_BITS   = 6;
    localparam int MODE_BITS  = 2;
    localparam int ADDR_BITS  = 2 * V_BITS;
    localparam int MAT_DEPTH  = MAX_V * MAX_V;
    localparam int VCOUNT_RST = 32;

    localparam int IN_RAW   = MODE_BITS + 2 * V_BITS + W_BITS;
    localparam int IN_BITS  = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW  = 2 * V_BITS + W_BITS + SUM_BITS;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

    // missing edge: one above the largest weight
    localparam logic [C_BITS-1:0]   INF_COST = {1'b1, {W_BITS{1'b0}}};
    localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};

    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RUN   = 2'd2;

    typedef struct packed {
        logic              init;     // start of run: reset costs and marks
        logic              relax;    // compare matrix word against cost[idx]
        logic              scan;     // compare cost[idx] against best
        logic              scan_clr; // open a new minimum search
        logic              mark;     // mark the picked vertex as in tree
        logic [V_BITS-1:0] idx;
    } t_sel_ctl;

    typedef struct packed {
        logic [V_BITS-1:0] pick;
        logic [V_BITS-1:0] parent;
        logic [C_BITS-1:0] best;
        logic              found;
    } t_sel_stat;

endpackage

`default_nettype wire

FILE: rtl/pmst_ram.sv
// ----------------------------------------------------------------------------
// pmst_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmst_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/pmst_sel.sv
// ----------------------------------------------------------------------------
// pmst_sel
// Per-vertex cost, parent and tree marks around one shared comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "prim_min_spanning_tree_unit_defines.svh"

module pmst_sel (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pmst_pkg::t_sel_ctl           i_ctl,
    input  wire logic [pmst_pkg::C_BITS-1:0]  i_rd_cost,
    output pmst_pkg::t_sel_stat               o_stat
);

    logic [pmst_pkg::C_BITS-1:0] r_cost   [pmst_pkg::MAX_V];
    logic [pmst_pkg::V_BITS-1:0] r_parent [pmst_pkg::MAX_V];
    logic [pmst_pkg::MAX_V-1:0]  r_in_tree;
    logic [pmst_pkg::C_BITS-1:0] r_best;
    logic [pmst_pkg::V_BITS-1:0] r_pick;
    logic                        r_found;

    logic [pmst_pkg::C_BITS-1:0] w_cur;
    logic [pmst_pkg::C_BITS-1:0] w_cmp_a;
    logic [pmst_pkg::C_BITS-1:0] w_cmp_b;
    logic                        w_take;

    // shared comparator: relax checks the new edge, scan checks the minimum
    always_comb begin
        w_cur   = r_cost[i_ctl.idx];
        w_cmp_a = i_ctl.relax ? i_rd_cost : w_cur;
        w_cmp_b = i_ctl.relax ? w_cur     : r_best;
        w_take  = (w_cmp_a < w_cmp_b) && !r_in_tree[i_ctl.idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            for (int k = 0; k < pmst_pkg::MAX_V; k++) begin
                r_cost[k]   <= pmst_pkg::INF_COST;
                r_parent[k] <= '0;
            end
        end else if (i_ctl.relax && w_take) begin
            r_cost[i_ctl.idx]   <= i_rd_cost;
            r_parent[i_ctl.idx] <= r_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tree <= '0;
            r_best    <= pmst_pkg::INF_COST;
            r_pick    <= '0;
            r_found   <= 1'b0;
        end else begin
            if (i_ctl.init) begin
                r_in_tree <= pmst_pkg::MAX_V'(1);
                r_pick    <= '0;
                r_found   <= 1'b0;
            end else if (i_ctl.mark) begin
                r_in_tree[r_pick] <= 1'b1;
            end
            if (i_ctl.scan_clr) begin
                r_best  <= pmst_pkg::INF_COST;
                r_found <= 1'b0;
            end else if (i_ctl.scan && w_take) begin
                r_best  <= w_cur;
                r_pick  <= i_ctl.idx;
                r_found <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.pick   = r_pick;
        o_stat.parent = r_parent[r_pick];
        o_stat.best   = r_best;
        o_stat.found  = r_found;
    end

    `PMST_ASSERT(a_join_new_vertex, i_ctl.mark |-> !r_in_tree[r_pick])
    `PMST_ASSERT_ALWAYS(a_found_finite, r_found |-> (r_best < pmst_pkg::INF_COST))

endmodule

`default_nettype wire

FILE: rtl/prim_min_spanning_tree_unit.sv
// ----------------------------------------------------------------------------
// prim_min_spanning_tree_unit
// Adjacency matrix store with a Prim minimum spanning tree sequencer.
// ----------------------------------------------------------------------------
// Clear: one matrix word per cycle over the whole matrix; add edge: the edge
//   word at accept, then its mirror word. Run: per tree edge, a read of the
//   new vertex's row with relax compares, then a minimum search over the costs,
//   all on one comparator and the single matrix read port. One transaction at a time.
// Reset: synchronous active low; then a clearing pass of the matrix
//   with s_axis_tready low (configuration writes still taken).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "prim_min_spanning_tree_unit_defines.svh"

module prim_min_spanning_tree_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tdata: mode, first_vertex, second_vertex, weight_in (low bits first)
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [pmst_pkg::IN_BITS-1:0]     s_axis_tdata,
    // tdata: from_vertex, to_vertex, tree_edge_weight, total_length
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [pmst_pkg::OUT_BITS-1:0]         m_axis_tdata,
    output logic                                  m_axis_tlast,
    // tuser: unreachable
    output logic                                  m_axis_tuser,
    // vertex_count register
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [pmst_pkg::CNT_BITS-1:0]    i_cfg_data
);

    localparam logic [2:0] S_SWEEP  = 3'd0;  // write infinite over the matrix
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EDGE2  = 3'd2;  // mirror write of an added edge
    localparam logic [2:0] S_RELAX  = 3'd3;  // read row of new vertex, relax
    localparam logic [2:0] S_RDRAIN = 3'd4;  // last relax compare in flight
    localparam logic [2:0] S_SCAN   = 3'd5;  // minimum search over costs
    localparam logic [2:0] S_EMIT   = 3'd6;  // hand result to output register

    // ---------------- registers ----------------
    logic [2:0]                    r_state, n_state;
    logic [pmst_pkg::ADDR_BITS-1:0] r_sweep, n_sweep;
    logic [pmst_pkg::V_BITS-1:0]   r_j, n_j;
    logic [pmst_pkg::V_BITS-1:0]   r_round, n_round;
    logic [pmst_pkg::SUM_BITS-1:0] r_sum, n_sum;
    logic                          r_rd_v, n_rd_v;
    logic [pmst_pkg::V_BITS-1:0]   r_rd_j, n_rd_j;
    logic [pmst_pkg::CNT_BITS-1:0] r_vcount;
    logic [pmst_pkg::V_BITS-1:0]   r_ea;
    logic [pmst_pkg::V_BITS-1:0]   r_eb;
    logic [pmst_pkg::W_BITS-1:0]   r_ew;
    logic                          r_out_valid;
    logic [pmst_pkg::OUT_BITS-1:0] r_out_data;
    logic                          r_out_last;
    logic                          r_out_unr;

    // ---------------- decode ----------------
    logic [pmst_pkg::MODE_BITS-1:0] w_mode;
    logic [pmst_pkg::V_BITS-1:0]    w_a;
    logic [pmst_pkg::V_BITS-1:0]    w_b;
    logic [pmst_pkg::W_BITS-1:0]    w_w;
    logic                           w_in_acc;
    logic                           w_add_ok;
    logic [pmst_pkg::V_BITS-1:0]    w_n_last;   // effective vertex count minus one
    logic                           w_out_free;
    logic                           w_out_load;
    logic                           w_last_nxt;
    logic [pmst_pkg::SUM_BITS:0]    w_sum_add;
    logic [pmst_pkg::SUM_BITS-1:0]  w_sum_sat;

    // ---------------- matrix port and select unit ----------------
    logic                           w_we;
    logic [pmst_pkg::ADDR_BITS-1:0] w_waddr;
    logic [pmst_pkg::C_BITS-1:0]    w_wdata;
    logic [pmst_pkg::ADDR_BITS-1:0] w_raddr;
    logic [pmst_pkg::C_BITS-1:0]    w_rdata;
    pmst_pkg::t_sel_ctl             w_ctl;
    pmst_pkg::t_sel_stat            w_stat;

    assign w_mode = s_axis_tdata[pmst_pkg::MODE_BITS-1:0];
    assign w_a    = s_axis_tdata[pmst_pkg::MODE_BITS +: pmst_pkg::V_BITS];
    assign w_b    = s_axis_tdata[pmst_pkg::MODE_BITS + pmst_pkg::V_BITS +: pmst_pkg::V_BITS];
    assign w_w    = s_axis_tdata[pmst_pkg::MODE_BITS + 2 * pmst_pkg::V_BITS +: pmst_pkg::W_BITS];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Count of zero acts as one, above the maximum acts as the maximum
    always_comb begin
        priority if (r_vcount == '0) begin
            w_n_last = '0;
        end else if (r_vcount > pmst_pkg::CNT_BITS'(pmst_pkg::MAX_V)) begin
            w_n_last = pmst_pkg::V_BITS'(pmst_pkg::MAX_V - 1);
        end else begin
            w_n_last = pmst_pkg::V_BITS'(r_vcount - 1'b1);
        end
    end

    // Drop an edge whose end lies outside the active vertices
    assign w_add_ok = (w_a <= w_n_last) && (w_b <= w_n_last);

    // Running total, saturating
    assign w_sum_add = {1'b0, r_sum} + (pmst_pkg::SUM_BITS + 1)'(w_stat.best[pmst_pkg::W_BITS-1:0]);
    assign w_sum_sat = w_sum_add[pmst_pkg::SUM_BITS] ? pmst_pkg::SUM_MAX
                                                     : w_sum_add[pmst_pkg::SUM_BITS-1:0];

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = (r_state == S_EMIT) && w_out_free;
    assign w_last_nxt = !w_stat.found || (r_round == w_n_last);

    // Matrix write port: sweep, first edge write at accept, mirror write after
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = pmst_pkg::INF_COST;
        priority if (r_state == S_SWEEP) begin
            w_we    = 1'b1;
            w_waddr = r_sweep;
        end else if (w_in_acc && (w_mode == pmst_pkg::MODE_ADD) && w_add_ok) begin
            w_we    = 1'b1;
            w_waddr = {w_a, w_b};
            w_wdata = {1'b0, w_w};
        end else if (r_state == S_EDGE2) begin
            w_we    = 1'b1;
            w_waddr = {r_eb, r_ea};
            w_wdata = {1'b0, r_ew};
        end
    end

    // Read the row of the vertex that just joined
    assign w_raddr = {w_stat.pick, r_j};

    always_comb begin
        w_ctl.init     = w_in_acc && (w_mode == pmst_pkg::MODE_RUN) && (w_n_last != '0);
        w_ctl.relax    = r_rd_v;
        w_ctl.scan     = (r_state == S_SCAN);
        w_ctl.scan_clr = (r_state == S_RDRAIN);
        w_ctl.mark     = w_out_load && w_stat.found;
        w_ctl.idx      = r_rd_v ? r_rd_j : r_j;
    end

    pmst_ram #(
        .WIDTH (pmst_pkg::C_BITS),
        .DEPTH (pmst_pkg::MAT_DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pmst_sel u_sel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_cost (w_rdata),
        .o_stat    (w_stat)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_j     = r_j;
        n_round = r_round;
        n_sum   = r_sum;
        n_rd_v  = 1'b0;
        n_rd_j  = r_j;
        unique case (r_state)
            S_SWEEP: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == pmst_pkg::ADDR_BITS'(pmst_pkg::MAT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_mode)
                        pmst_pkg::MODE_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        pmst_pkg::MODE_ADD: begin
                            if (w_add_ok) begin
                                n_state = S_EDGE2;
                            end
                        end
                        pmst_pkg::MODE_RUN: begin
                            // single vertex: nothing to emit
                            if (w_n_last != '0) begin
                                n_sum   = '0;
                                n_round = pmst_pkg::V_BITS'(1);
                                n_j     = pmst_pkg::V_BITS'(1);
                                n_state = S_RELAX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EDGE2: begin
                n_state = S_IDLE;
            end
            S_RELAX: begin
                n_rd_v = 1'b1;
                n_rd_j = r_j;
                if (r_j == w_n_last) begin
                    n_state = S_RDRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_RDRAIN: begin
                n_j     = pmst_pkg::V_BITS'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_j == w_n_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (!w_stat.found) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sum = w_sum_sat;
                        if (r_round == w_n_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_round = r_round + 1'b1;
                            n_j     = pmst_pkg::V_BITS'(1);
                            n_state = S_RELAX;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_j         <= '0;
            r_round     <= '0;
            r_sum       <= '0;
            r_rd_v      <= 1'b0;
            r_vcount    <= pmst_pkg::CNT_BITS'(pmst_pkg::VCOUNT_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_j     <= n_j;
            r_round <= n_round;
            r_sum   <= n_sum;
            r_rd_v  <= n_rd_v;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold edge fields for the mirror write, load results
    always_ff @(posedge i_clk) begin
        r_rd_j <= n_rd_j;
        if (w_in_acc) begin
            r_ea <= w_a;
            r_eb <= w_b;
            r_ew <= w_w;
        end
        if (w_out_load) begin
            if (w_stat.found) begin
                r_out_data <= pmst_pkg::OUT_BITS'({w_sum_sat,
                                                   w_stat.best[pmst_pkg::W_BITS-1:0],
                                                   w_stat.pick, w_stat.parent});
            end else begin
                r_out_data <= pmst_pkg::OUT_BITS'({r_sum,
                                                   {pmst_pkg::W_BITS{1'b0}},
                                                   {pmst_pkg::V_BITS{1'b0}},
                                                   {pmst_pkg::V_BITS{1'b0}}});
            end
            r_out_last <= w_last_nxt;
            r_out_unr  <= !w_stat.found;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_unr;

    // ---------------- checks ----------------
    `PMST_ASSERT(a_rd_from_relax, r_rd_v |-> ($past(r_state) == S_RELAX))
    `PMST_ASSERT(a_last_ends_run, (w_out_load && w_last_nxt) |=> (r_state == S_IDLE))
    `PMST_ASSERT(a_sum_grows,
        ((r_state != S_IDLE) && ($past(r_state) != S_IDLE)) |-> (r_sum >= $past(r_sum)))

endmodule

`default_nettype wire

FILE: tb/prim_min_spanning_tree_unit_tb.sv
// ----------------------------------------------------------------------------
// Self-checking bench for the Prim spanning tree unit
// Loads edges into the adjacency store, runs the tree search and checks every
// tree edge on the result stream against an in-bench predictor of the matrix
// and the search, or the edges of a typed directed row. A short directed table
// comes first, then random graphs of mixed sizes under random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prim_min_spanning_tree_unit_tb;

    import pmst_pkg::*;

    // mode 3 has no meaning; the block drops it
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    localparam int TOTAL_ITEMS = 320;  // useful items, directed rows included
    localparam int CALM_TAIL   = 40;   // last items go without any idling
    localparam int CLEAR_HOLD  = 1100; // hold after a clear, which keeps the block busy sweeping
    localparam int SHORT_HOLD  = 64;   // settle time after add edge or a run
    localparam int DRAIN_WAIT  = 2200; // catch stray results after the last one
    localparam int STALL_LIMIT = 20000;

    // One input item, packed so that mode sits in the lowest bits
    typedef struct packed {
        logic [W_BITS-1:0]    weight;
        logic [V_BITS-1:0]    vb;
        logic [V_BITS-1:0]    va;
        logic [MODE_BITS-1:0] mode;
    } t_item;

    // One tree edge as it leaves the block
    typedef struct packed {
        logic [V_BITS-1:0]   from_v;
        logic [V_BITS-1:0]   to_v;
        logic [W_BITS-1:0]   weight;
        logic [SUM_BITS-1:0] total;
        logic                unreach;
        logic                fin;
    } t_edge_result;

    typedef enum bit {STEP_ITEM, STEP_CFG} t_step_kind;

    // Row of the directed table; typed rows carry their tree edges inline
    typedef struct {
        t_step_kind          kind;
        t_item               item;
        logic [CNT_BITS-1:0] count;
        bit                  typed;
        int                  n_exp;
        t_edge_result        exp [2];
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_BITS-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CNT_BITS-1:0]   i_cfg_data = '0;

    // Predictor state: mirror of the adjacency store and the count register
    logic [C_BITS-1:0]     adj [MAX_V][MAX_V];
    logic [CNT_BITS-1:0]   vertex_cfg;

    t_edge_result          pending_edges [$];
    int unsigned           err_count;
    int unsigned           edges_checked;
    int unsigned           work_items;
    int unsigned           runs_done;
    int unsigned           cfg_writes;
    int unsigned           idle_cycles;
    int unsigned           rx_hold;
    bit                    rx_stall;
    bit                    calm;
    bit                    last_was_clear;

    prim_min_spanning_tree_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Zero acts as one vertex, anything above the store size as the full store
    function automatic int unsigned live_vertices();
        if (vertex_cfg == 0)
            return 1;
        if (vertex_cfg > MAX_V)
            return MAX_V;
        return vertex_cfg;
    endfunction

    function automatic void clear_adjacency();
        foreach (adj[i, j])
            adj[i][j] = INF_COST;
    endfunction

    // Grow the tree from vertex 0, one pick per pass. Marks are kept apart
    // from the costs, so a zero-weight edge is an edge like any other.
    function automatic void predict_tree_edges(ref t_edge_result out_q[$]);
        int unsigned       n;
        int unsigned       pick;
        int unsigned       sum;
        logic [C_BITS-1:0] cost [MAX_V];
        logic [V_BITS-1:0] par [MAX_V];
        bit                joined [MAX_V];
        logic [C_BITS-1:0] best;
        bit                found;
        t_edge_result      r;
        n = live_vertices();
        sum = 0;
        for (int i = 0; i < n; i++) begin
            cost[i] = adj[0][i];
            par[i] = '0;
            joined[i] = 1'b0;
        end
        joined[0] = 1'b1;
        cost[0] = '0;
        for (int i = 1; i < n; i++) begin
            best = INF_COST;
            pick = 0;
            found = 1'b0;
            // strict compare keeps the lowest index on a tie
            for (int j = 1; j < n; j++) begin
                if (!joined[j] && cost[j] < best) begin
                    best = cost[j];
                    pick = j;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // rest of the graph cut off: one closing result, then stop
                r = '0;
                r.total = sum[SUM_BITS-1:0];
                r.unreach = 1'b1;
                r.fin = 1'b1;
                out_q.push_back(r);
                return;
            end
            joined[pick] = 1'b1;
            sum += best;
            if (sum > SUM_MAX)
                sum = SUM_MAX;
            r.from_v = par[pick];
            r.to_v = pick[V_BITS-1:0];
            r.weight = best[W_BITS-1:0];
            r.total = sum[SUM_BITS-1:0];
            r.unreach = 1'b0;
            r.fin = (i == n - 1);
            out_q.push_back(r);
            for (int j = 1; j < n; j++) begin
                if (!joined[j] && adj[pick][j] < cost[j]) begin
                    cost[j] = adj[pick][j];
                    par[j] = pick[V_BITS-1:0];
                end
            end
        end
    endfunction

    // Advance the predictor by one accepted item; tree edges go to out_q
    function automatic void apply_item(input t_item it, ref t_edge_result out_q[$]);
        int unsigned n;
        n = live_vertices();
        case (it.mode)
            MODE_CLEAR: begin
                clear_adjacency();
                work_items++;
            end
            MODE_ADD: begin
                // an edge reaching past the live vertices is dropped
                if (it.va < n && it.vb < n) begin
                    adj[it.va][it.vb] = {1'b0, it.weight};
                    adj[it.vb][it.va] = {1'b0, it.weight};
                    work_items++;
                end
            end
            MODE_RUN: begin
                predict_tree_edges(out_q);
                work_items++;
                runs_done++;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_item make_item(logic [MODE_BITS-1:0] mode, int a, int b, int w);
        t_item it;
        it.mode = mode;
        it.va = a[V_BITS-1:0];
        it.vb = b[V_BITS-1:0];
        it.weight = w[W_BITS-1:0];
        return it;
    endfunction

    // Fields that the mode ignores still get random content
    function automatic t_item rand_item(logic [MODE_BITS-1:0] mode);
        return make_item(mode, $urandom_range(0, MAX_V - 1), $urandom_range(0, MAX_V - 1),
                         $urandom_range(0, 65535));
    endfunction

    // Favor the extremes and small values, so ties come up often
    function automatic int pick_weight();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65535;
            2, 3, 4, 5: return $urandom_range(0, 15);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic t_edge_result res(int from_v, int to_v, int w, int tot, bit unr, bit fin);
        t_edge_result r;
        r.from_v = from_v[V_BITS-1:0];
        r.to_v = to_v[V_BITS-1:0];
        r.weight = w[W_BITS-1:0];
        r.total = tot[SUM_BITS-1:0];
        r.unreach = unr;
        r.fin = fin;
        return r;
    endfunction

    function automatic t_step item_row(logic [MODE_BITS-1:0] mode, int a, int b, int w);
        t_step s;
        s.kind = STEP_ITEM;
        s.item = make_item(mode, a, b, w);
        s.count = '0;
        s.typed = 1'b0;
        s.n_exp = 0;
        s.exp[0] = '0;
        s.exp[1] = '0;
        return s;
    endfunction

    function automatic t_step typed_row(t_step s, int n_exp, t_edge_result e0,
                                        t_edge_result e1);
        s.typed = 1'b1;
        s.n_exp = n_exp;
        s.exp[0] = e0;
        s.exp[1] = e1;
        return s;
    endfunction

    function automatic t_step cfg_row(logic [CNT_BITS-1:0] value);
        t_step s;
        s = item_row(MODE_CLEAR, 0, 0, 0);
        s.kind = STEP_CFG;
        s.count = value;
        return s;
    endfunction

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    // Drive one item at the falling edge, maybe after a gap, and hold it
    // until the block takes it. Returns at the accepting rising edge.
    task automatic send_item(input t_item it);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = IN_BITS'(it);
        do @(posedge i_clk); while (!s_axis_tready);
        last_was_clear = (it.mode == MODE_CLEAR);
    endtask

    // Send an item and queue whatever tree edges the predictor gives
    task automatic feed(input t_item it);
        t_edge_result got [$];
        send_item(it);
        apply_item(it, got);
        foreach (got[k])
            pending_edges.push_back(got[k]);
        calm = (work_items + CALM_TAIL >= TOTAL_ITEMS);
    endtask

    // Drop valid, let every expected edge arrive, then let a clear or an
    // add edge finish inside the block, which gives no result to wait on.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_edges.size() != 0)
            @(posedge i_clk);
        repeat (last_was_clear ? CLEAR_HOLD : SHORT_HOLD) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_BITS-1:0] value);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        vertex_cfg = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Either a mode-3 item or an add edge aimed past the live vertices
    task automatic feed_noise();
        int unsigned n;
        int unsigned hi;
        n = live_vertices();
        if (n < MAX_V && $urandom_range(0, 1) == 0) begin
            hi = $urandom_range(n, MAX_V - 1);
            if ($urandom_range(0, 1) == 0)
                feed(make_item(MODE_ADD, hi, $urandom_range(0, MAX_V - 1), pick_weight()));
            else
                feed(make_item(MODE_ADD, $urandom_range(0, MAX_V - 1), hi, pick_weight()));
        end else begin
            feed(rand_item(MODE_UNUSED));
        end
    endtask

    task automatic add_edge(input int unsigned a, input int unsigned b);
        if ($urandom_range(0, 9) == 0)
            feed_noise();
        if ($urandom_range(0, 1) == 0)
            feed(make_item(MODE_ADD, a, b, pick_weight()));
        else
            feed(make_item(MODE_ADD, b, a, pick_weight()));
    endtask

    // One random graph: maybe a new size, maybe a clear, a random spanning tree
    // in most cases, some extra edges, then one or two runs.
    task automatic random_phase();
        int unsigned         sel;
        int unsigned         n;
        int unsigned         extra;
        logic [CNT_BITS-1:0] cnt;
        if ($urandom_range(0, 2) != 0) begin
            sel = $urandom_range(0, 19);
            if (sel < 12)
                cnt = $urandom_range(2, 8);
            else if (sel < 15)
                cnt = $urandom_range(9, 31);
            else if (sel == 15)
                cnt = MAX_V;
            else if (sel == 16)
                cnt = '1;
            else if (sel == 17)
                cnt = $urandom_range(33, 62);
            else if (sel == 18)
                cnt = '0;
            else
                cnt = 1;
            write_vertex_count(cnt);
        end
        n = live_vertices();
        if ($urandom_range(0, 3) == 0)
            feed(rand_item(MODE_CLEAR));
        if ($urandom_range(0, 3) != 0) begin
            for (int v = 1; v < n; v++)
                add_edge(v, $urandom_range(0, v - 1));
        end
        extra = $urandom_range(0, n);
        repeat (extra) add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        feed(rand_item(MODE_RUN));
        if ($urandom_range(0, 4) == 0)
            feed(rand_item(MODE_RUN));
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready bursts, then check each edge in order
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            rx_stall = !calm && ($urandom_range(0, 2) == 0);
            rx_hold = rx_stall ? $urandom_range(1, 14) : $urandom_range(1, 30);
        end
        rx_hold--;
        m_axis_tready = !rx_stall;
    end

    always @(posedge i_clk) begin : result_check
        t_edge_result seen;
        t_edge_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.from_v = m_axis_tdata[V_BITS-1:0];
            seen.to_v = m_axis_tdata[2*V_BITS-1:V_BITS];
            seen.weight = m_axis_tdata[2*V_BITS+W_BITS-1:2*V_BITS];
            seen.total = m_axis_tdata[OUT_RAW-1:2*V_BITS+W_BITS];
            seen.unreach = m_axis_tuser;
            seen.fin = m_axis_tlast;
            if (pending_edges.size() == 0) begin
                flag_error($sformatf("unexpected result from=%0d to=%0d w=%0d sum=%0d unr=%0b last=%0b",
                                     seen.from_v, seen.to_v, seen.weight, seen.total,
                                     seen.unreach, seen.fin));
            end else begin
                want = pending_edges.pop_front();
                edges_checked++;
                if (seen.from_v !== want.from_v || seen.to_v !== want.to_v ||
                    seen.weight !== want.weight || seen.total !== want.total ||
                    seen.unreach !== want.unreach || seen.fin !== want.fin) begin
                    flag_error($sformatf({"result %0d: exp from=%0d to=%0d w=%0d sum=%0d ",
                                          "unr=%0b last=%0b, got from=%0d to=%0d w=%0d ",
                                          "sum=%0d unr=%0b last=%0b"},
                                         edges_checked, want.from_v, want.to_v, want.weight,
                                         want.total, want.unreach, want.fin, seen.from_v,
                                         seen.to_v, seen.weight, seen.total, seen.unreach,
                                         seen.fin));
                end
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_edges.size());
            $display("prim_min_spanning_tree_unit_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_step        plan [$];
        t_edge_result got [$];

        clear_adjacency();
        vertex_cfg = VCOUNT_RST;

        // Hold reset, then release it at a falling edge
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Taken during the clearing pass that follows reset
        write_vertex_count(VCOUNT_RST);

        // Directed table, full 32 vertices first
        plan.push_back(typed_row(item_row(MODE_RUN, 0, 0, 0), 1,
                                 res(0, 0, 0, 0, 1, 1), '0));     // empty store: cut off
        plan.push_back(item_row(MODE_ADD, 0, 31, 65535));         // highest vertex, max weight
        plan.push_back(typed_row(item_row(MODE_RUN, 31, 31, 65535), 2,
                                 res(0, 31, 65535, 65535, 0, 0),
                                 res(0, 0, 0, 65535, 1, 1)));
        plan.push_back(item_row(MODE_ADD, 31, 31, 0));            // self loop, no effect
        plan.push_back(item_row(MODE_ADD, 5, 7, 0));              // zero-weight edges
        plan.push_back(item_row(MODE_ADD, 0, 5, 0));
        plan.push_back(item_row(MODE_ADD, 7, 31, 1));
        plan.push_back(item_row(MODE_ADD, 0, 3, 10));             // equal costs: 2 wins
        plan.push_back(item_row(MODE_ADD, 2, 0, 10));
        plan.push_back(item_row(MODE_UNUSED, 31, 31, 65535));     // dropped
        plan.push_back(item_row(MODE_RUN, 0, 0, 0));
        plan.push_back(item_row(MODE_CLEAR, 31, 0, 65535));
        plan.push_back(typed_row(item_row(MODE_RUN, 0, 0, 0), 1,
                                 res(0, 0, 0, 0, 1, 1), '0));
        // Single vertex: edges past it are dropped, a run gives nothing
        plan.push_back(cfg_row(1));
        plan.push_back(item_row(MODE_ADD, 0, 1, 7));
        plan.push_back(item_row(MODE_RUN, 0, 0, 0));
        plan.push_back(cfg_row(0));                               // acts as one vertex
        plan.push_back(item_row(MODE_RUN, 0, 0, 0));
        plan.push_back(cfg_row(2));
        plan.push_back(typed_row(item_row(MODE_RUN, 0, 0, 0), 1,
                                 res(0, 0, 0, 0, 1, 1), '0));     // dropped edge left no trace
        plan.push_back(item_row(MODE_ADD, 1, 0, 5));
        plan.push_back(typed_row(item_row(MODE_RUN, 0, 0, 0), 1,
                                 res(0, 1, 5, 5, 0, 1), '0));
        plan.push_back(item_row(MODE_ADD, 1, 2, 3));              // vertex 2 not live
        plan.push_back(cfg_row('1));                              // 63 acts as 32
        plan.push_back(typed_row(item_row(MODE_RUN, 0, 0, 0), 2,
                                 res(0, 1, 5, 5, 0, 0), res(0, 0, 0, 5, 1, 1)));

        foreach (plan[p]) begin
            if (plan[p].kind == STEP_CFG) begin
                write_vertex_count(plan[p].count);
            end else if (plan[p].typed) begin
                // advance the predictor's state, trust the typed edges
                send_item(plan[p].item);
                got.delete();
                apply_item(plan[p].item, got);
                for (int k = 0; k < plan[p].n_exp; k++)
                    pending_edges.push_back(plan[p].exp[k]);
            end else begin
                feed(plan[p].item);
            end
        end

        // Random graphs until the item budget is spent
        while (work_items < TOTAL_ITEMS)
            random_phase();

        // Drain: every expected edge in, then a quiet stretch for strays
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_edges.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d tree results from %0d spanning tree runs, %0d items in all.",
                 edges_checked, runs_done, work_items);
        $display("Vertex count written %0d times, sizes from one vertex to the full store.",
                 cfg_writes);
        if (err_count == 0) begin
            $display("prim_min_spanning_tree_unit_tb OK");
        end else begin
            $display("%0d mismatches in total", err_count);
            $display("prim_min_spanning_tree_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pmst_pkg.sv
rtl/pmst_ram.sv
rtl/pmst_sel.sv
rtl/prim_min_spanning_tree_unit.sv
tb/prim_min_spanning_tree_unit_tb.sv
